// ===== hdl/icmp_erc_pkg.sv =====
// Shared types, constants and helpers for the ICMP echo reply checker.
package icmp_erc_pkg;

  localparam logic [15:0] MAX_POS        = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [15:0] POS_VER_IHL    = 16'd0;
  localparam logic [15:0] POS_TLEN_HI    = 16'd2;
  localparam logic [15:0] POS_TLEN_LO    = 16'd3;
  localparam logic [15:0] POS_TTL        = 16'd8;
  localparam logic [15:0] IP_MIN_BYTES   = 16'd20;
  localparam logic [3:0]  IP_MIN_WORDS   = 4'd5;
  localparam logic [15:0] OFF_ID_HI      = 16'd4;
  localparam logic [15:0] OFF_ID_LO      = 16'd5;
  localparam logic [15:0] OFF_SEQ_HI     = 16'd6;
  localparam logic [15:0] OFF_SEQ_LO     = 16'd7;
  localparam logic [15:0] ECHO_HDR_BYTES = 16'd8;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_ID_MISM   = 2'd2,
    ST_LEN_ERROR = 2'd3
  } status_t;

  // Per-packet state; also the snapshot of a finished packet.
  typedef struct packed {
    logic [15:0] byte_pos;
    logic [3:0]  hdr_words;
    logic [15:0] total_len;
    logic [7:0]  ttl_seen;
    logic [15:0] ones_sum;
    logic [7:0]  high_pending;
    logic [15:0] ident_seen;
    logic [15:0] seq_seen;
  } pkt_state_t;

  // Ones' complement 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== hdl/icmp_erc_ifs.sv =====
// Channel interfaces: packet bytes in, results out, configuration write.
interface icmp_erc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;
  modport source (output valid, pkt_byte, last_byte, input ready);
  modport sink   (input valid, pkt_byte, last_byte, output ready);
endinterface

interface icmp_erc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] echo_seq;
  logic [7:0]  hop_limit;
  logic [15:0] icmp_len;
  modport source (output valid, status, echo_seq, hop_limit, icmp_len, input ready);
  modport sink   (input valid, status, echo_seq, hop_limit, icmp_len, output ready);
endinterface

interface icmp_erc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] echo_ident;
  modport source (output valid, echo_ident, input ready);
  modport sink   (input valid, echo_ident, output ready);
endinterface

// ===== hdl/icmp_echo_reply_checker_unit.sv =====
// ICMP echo reply checker top level: byte accumulator feeding the result stage.
// Throughput: one packet word (byte) per clock, sustained; a stalled result
// stage backs up through one snapshot register before input ready drops.
// A packet's result passes the snapshot register, then the result register.
// Reset (rst, synchronous, active high) clears the packet state, the valid
// bits and the expected identifier; no clearing pass, ready right after reset.
module icmp_echo_reply_checker_unit
  import icmp_erc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  icmp_erc_byte_if.sink   pkt,
  icmp_erc_cfg_if.sink    cfg,
  icmp_erc_res_if.source  res
);

  // Snapshot of a finished packet, handed from the accumulator to the
  // result stage. The snapshot register lets the accumulator start the next
  // packet while the previous result still waits at the output.
  logic       snap_valid;
  logic       snap_ready;
  pkt_state_t snap;

  // Capture header fields and run the ones' complement sum, one word a clock unless a held snapshot stalls the input.
  icmp_erc_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // Fold the odd byte, rank the length, checksum and identifier checks,
  // and hold the result until the sink takes it.
  icmp_erc_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res        (res)
  );

endmodule

// ===== hdl/icmp_erc_acc.sv =====
// Byte accumulator: header capture, running checksum, packet snapshot.
module icmp_erc_acc
  import icmp_erc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  icmp_erc_byte_if.sink      pkt,
  output logic               snap_valid,
  input  logic               snap_ready,
  output pkt_state_t         snap
);

  pkt_state_t  st;
  pkt_state_t  st_next;
  logic [5:0]  hb;
  logic [15:0] off;
  logic        in_icmp;
  logic        accept;

  assign pkt.ready = !snap_valid || snap_ready;
  assign accept    = pkt.valid && pkt.ready;

  always_comb begin
    st_next = st;
    hb      = {st.hdr_words, 2'b00};
    off     = st.byte_pos - {10'd0, hb};
    in_icmp = (st.byte_pos >= IP_MIN_BYTES) && (st.hdr_words >= IP_MIN_WORDS) &&
              (st.byte_pos >= {10'd0, hb}) && (st.byte_pos < st.total_len);

    priority if (st.byte_pos == POS_VER_IHL) begin
      st_next.hdr_words = pkt.pkt_byte[3:0];
    end else if (st.byte_pos == POS_TLEN_HI) begin
      st_next.total_len[15:8] = pkt.pkt_byte;
    end else if (st.byte_pos == POS_TLEN_LO) begin
      st_next.total_len[7:0] = pkt.pkt_byte;
    end else if (st.byte_pos == POS_TTL) begin
      st_next.ttl_seen = pkt.pkt_byte;
    end else begin
    end

    if (in_icmp) begin
      if (!off[0]) begin
        st_next.high_pending = pkt.pkt_byte;
      end else begin
        st_next.ones_sum = oc_add(st.ones_sum, {st.high_pending, pkt.pkt_byte});
      end
      priority if (off == OFF_ID_HI) begin
        st_next.ident_seen[15:8] = pkt.pkt_byte;
      end else if (off == OFF_ID_LO) begin
        st_next.ident_seen[7:0] = pkt.pkt_byte;
      end else if (off == OFF_SEQ_HI) begin
        st_next.seq_seen[15:8] = pkt.pkt_byte;
      end else if (off == OFF_SEQ_LO) begin
        st_next.seq_seen[7:0] = pkt.pkt_byte;
      end else begin
      end
    end

    // Saturate the byte count.
    if (st.byte_pos != MAX_POS) begin
      st_next.byte_pos = st.byte_pos + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= pkt.last_byte ? '0 : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && pkt.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt.last_byte) begin
      snap <= st_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && pkt.last_byte |=> st == '0)
    else $error("packet state not cleared after last word");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_ready |=> snap_valid && $stable(snap))
    else $error("stalled snapshot changed");

  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(st))
    else $error("packet state moved without a word");

endmodule

// ===== hdl/icmp_erc_eval.sv =====
// Result stage: length checks, checksum fold, status and output register.
module icmp_erc_eval
  import icmp_erc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  icmp_erc_cfg_if.sink       cfg,
  input  logic               snap_valid,
  output logic               snap_ready,
  input  pkt_state_t         snap,
  icmp_erc_res_if.source     res
);

  logic [15:0] echo_ident;
  logic [15:0] hbytes;
  logic [15:0] ilen;
  logic [15:0] sum;
  status_t     status_next;

  assign cfg.ready  = 1'b1;
  assign snap_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_ident <= '0;
    end else if (cfg.valid) begin
      echo_ident <= cfg.echo_ident;
    end
  end

  always_comb begin
    hbytes = {10'd0, snap.hdr_words, 2'b00};
    ilen   = (snap.total_len >= hbytes) ? (snap.total_len - hbytes) : 16'd0;
    // Pad an odd final byte with zero.
    sum    = ilen[0] ? oc_add(snap.ones_sum, {snap.high_pending, 8'h00}) : snap.ones_sum;
    priority if (snap.hdr_words < IP_MIN_WORDS || snap.total_len < hbytes ||
                 snap.byte_pos < snap.total_len || ilen < ECHO_HDR_BYTES) begin
      status_next = ST_LEN_ERROR;
    end else if (sum != SUM_GOOD) begin
      status_next = ST_BAD_SUM;
    end else if (snap.ident_seen != echo_ident) begin
      status_next = ST_ID_MISM;
    end else begin
      status_next = ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      res.status    <= status_next;
      res.echo_seq  <= snap.seq_seen;
      res.hop_limit <= snap.ttl_seen;
      res.icmp_len  <= ilen;
    end
  end

  a_load_from_snap: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(snap_valid))
    else $error("result appeared without a finished packet");

endmodule
